[design/tosd_pkg.sv]
`timescale 1ns / 1ps
// Package for the track opcode stream decoder: phase type, opcode codes,
// field widths and stream bus packing. No dependencies.
package tosd_pkg;

    localparam int POSITION_WIDTH = 20;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int RATE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int SKIP_W   = 4;

    // slave side: tdata = raw_byte, tuser = track_start
    localparam int IN_TDATA_W = 8;
    localparam int IN_TUSER_W = 1;

    // master side tdata layout, lowest field first
    localparam int BITS_LSB  = 0;
    localparam int COUNT_LSB = BITS_LSB + BYTE_W;
    localparam int POS_LSB   = COUNT_LSB + COUNT_W;
    localparam int RATE_LSB  = POS_LSB + POSITION_WIDTH;
    localparam int OUT_FIELDS_W = RATE_LSB + RATE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    // master side tuser: index_mark, then status
    localparam int OUT_TUSER_W  = 1 + STATUS_W;

    localparam logic [3:0] OPCODE_PREFIX = 4'hF;
    localparam logic [3:0] OP_NOP     = 4'h0;
    localparam logic [3:0] OP_IDXMARK = 4'h1;
    localparam logic [3:0] OP_SETRATE = 4'h2;
    localparam logic [3:0] OP_SKIP    = 4'h3;

    localparam logic [BYTE_W-1:0] SKIP_LIMIT = 8'd8;

    typedef enum logic [1:0] {
        PH_OPCODE    = 2'd0,
        PH_RATE      = 2'd1,
        PH_SKIPCOUNT = 2'd2,
        PH_SKIPDATA  = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_OPCODE = 2'd1,
        ST_BAD_SKIP   = 2'd2
    } status_t;

endpackage

[design/track_opcode_stream_decoder.sv]
`timescale 1ns / 1ps
// Track opcode stream decoder: one stream byte in, one result item out.
// Depends on tosd_pkg.
//
//  channel | dir | tdata (low bit up)                              | tuser
//  s_*     | in  | raw_byte[7:0]                                   | track_start
//  m_*     | out | out_bits, out_count, out_position, bitrate     | index_mark, status
//
// One item per cycle while the output is not stalled; each item's result appears
// the cycle after it is taken. Decode is a single pass from the phase and position
// registers into the output register; the output register decouples the two sides,
// so a new item is taken whenever the output register is empty or being drained.
// Reset returns the decoder to the opcode phase with rate and position zero.
module track_opcode_stream_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tosd_pkg::IN_TDATA_W-1:0]   s_tdata,   // raw_byte
    input  logic [tosd_pkg::IN_TUSER_W-1:0]   s_tuser,   // track_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_bits, out_count, out_position, bitrate
    output logic [tosd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // index_mark, status
    output logic [tosd_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import tosd_pkg::*;

    phase_t                    phase_reg, phase_next, phase_cur;
    logic [SKIP_W-1:0]         skip_reg, skip_next, skip_cur;
    logic [RATE_W-1:0]         rate_reg, rate_next, rate_cur;
    logic [POSITION_WIDTH-1:0] pos_reg, pos_next, pos_cur;

    logic [BYTE_W-1:0]         b;
    logic [BYTE_W-1:0]         bits;
    logic [COUNT_W-1:0]        count;
    logic                      mark;
    status_t                   status;
    logic [SKIP_W-1:0]         shamt;
    logic [POSITION_WIDTH:0]   pos_sum;

    logic                      m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [OUT_TUSER_W-1:0]    m_tuser_reg;
    logic                      accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // stream is stored lsb first
    always_comb
    begin
        for (int k = 0; k < BYTE_W; k++)
        begin
            b[k] = s_tdata[BYTE_W-1-k];
        end
    end

    // track start clears state ahead of this item
    always_comb
    begin
        phase_cur = s_tuser[0] ? PH_OPCODE : phase_reg;
        skip_cur  = s_tuser[0] ? '0 : skip_reg;
        rate_cur  = s_tuser[0] ? '0 : rate_reg;
        pos_cur   = s_tuser[0] ? '0 : pos_reg;
    end

    always_comb
    begin
        phase_next = phase_cur;
        skip_next  = skip_cur;
        rate_next  = rate_cur;
        bits       = '0;
        count      = '0;
        mark       = 1'b0;
        status     = ST_OK;
        shamt      = (skip_cur > SKIP_W'(SKIP_LIMIT)) ? SKIP_W'(SKIP_LIMIT) : skip_cur;
        case (phase_cur)
            PH_RATE:
            begin
                rate_next  = b;
                phase_next = PH_OPCODE;
            end
            PH_SKIPCOUNT:
            begin
                if (b > SKIP_LIMIT)
                begin
                    status     = ST_BAD_SKIP;
                    phase_next = PH_OPCODE;
                end
                else
                begin
                    skip_next  = b[SKIP_W-1:0];
                    phase_next = PH_SKIPDATA;
                end
            end
            PH_SKIPDATA:
            begin
                count      = COUNT_W'(SKIP_LIMIT) - shamt;
                bits       = b << shamt;
                phase_next = PH_OPCODE;
            end
            default:
            begin
                if (b[7:4] == OPCODE_PREFIX)
                begin
                    case (b[3:0])
                        OP_NOP:     ;
                        OP_IDXMARK: mark = 1'b1;
                        OP_SETRATE: phase_next = PH_RATE;
                        OP_SKIP:    phase_next = PH_SKIPCOUNT;
                        default:    status = ST_BAD_OPCODE;
                    endcase
                end
                else
                begin
                    bits  = b;
                    count = COUNT_W'(BYTE_W);
                end
            end
        endcase
    end

    // advance position, hold at the top
    always_comb
    begin
        pos_sum  = {1'b0, pos_cur} + (POSITION_WIDTH+1)'(count);
        pos_next = pos_sum[POSITION_WIDTH] ? POS_MAX : pos_sum[POSITION_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPCODE;
            skip_reg  <= '0;
            rate_reg  <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            rate_reg  <= rate_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= OUT_TDATA_W'({rate_next, pos_cur, count, bits});
            m_tuser_reg <= {status, mark};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[design/tosd_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the track opcode stream decoder, bound to the top.
// Depends on tosd_pkg and track_opcode_stream_decoder.
module tosd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tosd_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic [tosd_pkg::OUT_TUSER_W-1:0]  m_tuser
);
    import tosd_pkg::*;

    logic [BYTE_W-1:0]  o_bits;
    logic [COUNT_W-1:0] o_count;

    assign o_bits  = m_tdata[BITS_LSB +: BYTE_W];
    assign o_count = m_tdata[COUNT_LSB +: COUNT_W];

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // every item taken gives a result in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // an error or an index mark emits nothing
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] || m_tuser[OUT_TUSER_W-1:1] != ST_OK) |-> o_count == '0)
        else $error("flagged item emitted bits");

    // count in range and bits below the valid ones are zero
    a_bits: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> o_count <= COUNT_W'(BYTE_W) && (o_bits & (8'hFF >> o_count)) == '0)
        else $error("emitted bits outside valid span");

endmodule

bind track_opcode_stream_decoder tosd_checker u_tosd_checker (.*);

[tb/sv/tb_track_opcode_stream_decoder.sv]
`timescale 1ns / 1ps
// Testbench for track_opcode_stream_decoder: directed and random items,
// each result checked against an in-bench decoder model.
// Depends on tosd_pkg and the decoder RTL.
module tb_track_opcode_stream_decoder;
    import tosd_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [BYTE_W-1:0]         bits;
        logic [COUNT_W-1:0]        count;
        logic [POSITION_WIDTH-1:0] pos;
        logic [RATE_W-1:0]         rate;
        logic                      mark;
        status_t                   status;
    } decoded_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // raw_byte
    logic [IN_TUSER_W-1:0]  s_tuser;    // track_start
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // out_bits, out_count, out_position, bitrate
    logic [OUT_TUSER_W-1:0] m_tuser;    // index_mark, status

    // decoder model state
    phase_t                    dec_phase;
    logic [SKIP_W-1:0]         dec_skip;
    logic [RATE_W-1:0]         dec_rate;
    logic [POSITION_WIDTH-1:0] dec_pos;

    decoded_t pending_results[$];
    int       cycles;
    int       mismatches;
    int       items_sent;
    int       results_seen;
    int       marks_seen;
    int       flagged_seen;
    bit       steady;
    int       stall_left;

    track_opcode_stream_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] reverse_byte(input logic [7:0] x);
        logic [7:0] y;
        for (int k = 0; k < 8; k++)
            y[k] = x[7-k];
        return y;
    endfunction

    // Gap length: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic decoded_t decode_byte(input logic [7:0] raw, input logic start);
        decoded_t   r;
        logic [7:0] b;
        logic [3:0] s;
        b = reverse_byte(raw);
        r = '0;
        r.status = ST_OK;
        if (start)
        begin
            dec_phase = PH_OPCODE;
            dec_skip  = '0;
            dec_rate  = '0;
            dec_pos   = '0;
        end
        r.pos = dec_pos;
        case (dec_phase)
            PH_RATE:
            begin
                dec_rate  = b;
                dec_phase = PH_OPCODE;
            end
            PH_SKIPCOUNT:
            begin
                if (b > SKIP_LIMIT)
                begin
                    r.status  = ST_BAD_SKIP;
                    dec_phase = PH_OPCODE;
                end
                else
                begin
                    dec_skip  = b[SKIP_W-1:0];
                    dec_phase = PH_SKIPDATA;
                end
            end
            PH_SKIPDATA:
            begin
                s = (dec_skip > 4'd8) ? 4'd8 : dec_skip;
                r.count   = 4'd8 - s;
                r.bits    = b << s;
                dec_phase = PH_OPCODE;
            end
            default:
            begin
                if (b[7:4] == OPCODE_PREFIX)
                begin
                    case (b[3:0])
                        OP_NOP:     ;
                        OP_IDXMARK: r.mark = 1'b1;
                        OP_SETRATE: dec_phase = PH_RATE;
                        OP_SKIP:    dec_phase = PH_SKIPCOUNT;
                        default:    r.status = ST_BAD_OPCODE;
                    endcase
                end
                else
                begin
                    r.bits  = b;
                    r.count = 4'd8;
                end
            end
        endcase
        r.rate = dec_rate;
        // hold the position at its maximum once it would overflow
        if (POS_MAX - dec_pos < POSITION_WIDTH'(r.count))
            dec_pos = POS_MAX;
        else
            dec_pos = dec_pos + POSITION_WIDTH'(r.count);
        return r;
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Send one item; value is the decoded byte, driven bit-reversed as stored.
    task automatic send_item(input logic [7:0] value, input logic start);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = reverse_byte(value);
        s_tuser  = start;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // One sequence with random content, well-formed or with a bad skip count, or a stray byte.
    task automatic random_sequence();
        int   r;
        logic start;
        r     = $urandom_range(0, 99);
        start = ($urandom_range(0, 39) == 0);
        if (r < 45)
            send_item(8'($urandom_range(8'h00, 8'hEF)), start);
        else if (r < 50)
            send_item({OPCODE_PREFIX, OP_NOP}, start);
        else if (r < 58)
            send_item({OPCODE_PREFIX, OP_IDXMARK}, start);
        else if (r < 66)
        begin
            send_item({OPCODE_PREFIX, OP_SETRATE}, start);
            send_item(8'($urandom), 1'b0);
        end
        else if (r < 84)
        begin
            send_item({OPCODE_PREFIX, OP_SKIP}, start);
            send_item(8'($urandom_range(0, 8)), 1'b0);
            send_item(8'($urandom), 1'b0);
        end
        else if (r < 88)
        begin
            send_item({OPCODE_PREFIX, OP_SKIP}, start);
            send_item(8'($urandom_range(9, 255)), 1'b0);
        end
        else if (r < 93)
            send_item(8'($urandom_range(8'hF4, 8'hFF)), start);
        else
            send_item(8'($urandom), start);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b1);
        send_item(8'hEF, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item({OPCODE_PREFIX, OP_NOP}, 1'b0);
        send_item({OPCODE_PREFIX, OP_IDXMARK}, 1'b0);
        // operand bytes are never opcodes
        send_item({OPCODE_PREFIX, OP_SETRATE}, 1'b0);
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item(8'd8, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item(8'd3, 1'b0);
        send_item(8'hC3, 1'b0);
        wait_drained();
        // bad skip count drops back to opcode decoding
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item(8'd9, 1'b0);
        send_item(8'h12, 1'b0);
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item({OPCODE_PREFIX, 4'h4}, 1'b0);
        send_item(8'hFF, 1'b0);
        // track start in the middle of a skip sequence
        send_item({OPCODE_PREFIX, OP_SKIP}, 1'b0);
        send_item({OPCODE_PREFIX, OP_IDXMARK}, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        int target;
        target = items_sent + 575;
        while (items_sent < target)
        begin
            random_sequence();
            if ($urandom_range(0, 9) == 0)
                steady = ~steady;
            if ($urandom_range(0, 79) == 0)
                wait_drained();
        end
        steady = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        steady   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();

        repeat (5) @(posedge clk);
        $display("Sent %0d items, checked %0d results: %0d index marks, %0d flagged bytes,",
                 items_sent, results_seen, marks_seen, flagged_seen);
        $display("%0d mismatches.", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Receiver stalls.
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                m_tready   = (stall_left == 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    always @(posedge clk)
    begin
        decoded_t want;
        decoded_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.bits   = m_tdata[BITS_LSB +: BYTE_W];
                got.count  = m_tdata[COUNT_LSB +: COUNT_W];
                got.pos    = m_tdata[POS_LSB +: POSITION_WIDTH];
                got.rate   = m_tdata[RATE_LSB +: RATE_W];
                got.mark   = m_tuser[0];
                got.status = status_t'(m_tuser[1 +: STATUS_W]);
                if (pending_results.size() == 0)
                    report("result item with no expectation pending");
                else
                begin
                    want = pending_results.pop_front();
                    results_seen++;
                    if (want.mark)
                        marks_seen++;
                    if (want.status != ST_OK)
                        flagged_seen++;
                    if (got.bits !== want.bits)
                        report($sformatf("out_bits %h, want %h", got.bits, want.bits));
                    if (got.count !== want.count)
                        report($sformatf("out_count %0d, want %0d", got.count, want.count));
                    if (got.pos !== want.pos)
                        report($sformatf("out_position %h, want %h", got.pos, want.pos));
                    if (got.rate !== want.rate)
                        report($sformatf("bitrate %h, want %h", got.rate, want.rate));
                    if (got.mark !== want.mark)
                        report($sformatf("index_mark %b, want %b", got.mark, want.mark));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, want %0d", got.status, want.status));
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(decode_byte(s_tdata, s_tuser[0]));
        end
    end

    initial
    begin
        dec_phase = PH_OPCODE;
        dec_skip  = '0;
        dec_rate  = '0;
        dec_pos   = '0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
